FILE: src/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types and constants for the next lexicographic permutation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nlp_pkg;

   localparam int ELEM_W = 16;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_SWAP_J,
      ST_SWAP_P,
      ST_REV_CHK,
      ST_REV_RD_LO,
      ST_REV_RD_HI,
      ST_REV_WR_LO,
      ST_REV_WR_HI,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   typedef logic signed [ELEM_W-1:0] elem_type;

   // Result flags, highest bit first on the tuser port
   typedef struct packed {
      logic overflow;
      logic found;
   } flags_type;

endpackage : nlp_pkg

`default_nettype wire

FILE: src/nlp_ram.sv
// ----------------------------------------------------------------------------
// nlp_ram
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nlp_ram #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [IDX_W-1:0]          wr_addr,
   input  wire nlp_pkg::elem_type         wr_data,
   input  wire logic                      rd_en,
   input  wire logic [IDX_W-1:0]          rd_addr,
   output nlp_pkg::elem_type              rd_data
);
   import nlp_pkg::*;

   elem_type mem [DEPTH];
   elem_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : nlp_ram

`default_nettype wire

FILE: src/next_lexicographic_permutation_top.sv
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_top
// Loads a sequence of signed elements and emits its next lexicographic
// permutation, one element per transfer.
// ----------------------------------------------------------------------------
// Usage
//   req_*: one element per transfer, tlast marks the final element. At most
//          MAX_LEN elements are kept; further ones are dropped and the
//          overflow flag is raised for the whole result frame.
//   rsp_*: the permuted sequence in order, tlast on the final element, tuser
//          carries {overflow, found}. found is clear when the input was
//          already the greatest arrangement; it is then returned unchanged.
// Operation (all accesses go through the element store's one read and one write port)
//   Loading accepts one element per cycle and req_tready stays high.
//   After the final element the block drops req_tready and runs its
//   sequencer: pivot scan with a read and a compare per element looked
//   at, search for the swap partner likewise, swap of partner and pivot,
//   suffix reversal with a check, two reads and two writes per swapped
//   pair plus one closing check, then a read and an output per element.
//   The sequencer shares the one signed comparator and the single read
//   port between its steps.
// Reset clears the element count, overflow flag and sequencer; the store
// itself is not cleared. A stall on rsp_tready simply holds the current
// result; the sequencer waits and req_tready stays low until the frame ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module next_lexicographic_permutation_top #(
   parameter int MAX_LEN = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,   // [15:0] elem_value
   input  wire logic         req_tlast,   // is_last
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,   // [15:0] out_value
   output logic [1:0]        rsp_tuser,   // [0] found, [1] overflow
   output logic              rsp_tlast    // out_last
);
   import nlp_pkg::*;

   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
   localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_ZERO = '0;

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   flags_type         flags_ff, flags_in;
   logic              first_ff, first_in;
   // working registers
   logic [IDX_W-1:0]  idx_ff, idx_in;    // scan / search / low / emit index
   logic [IDX_W-1:0]  hi_ff, hi_in;      // high end during reversal
   logic [IDX_W-1:0]  piv_ff, piv_in;    // pivot position
   elem_type          pval_ff, pval_in;  // pivot value
   elem_type          cur_ff, cur_in;    // held element

   // store port
   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   elem_type          wr_data, rd_data;

   // shared signed comparator
   elem_type          cmp_a, cmp_b;
   logic              cmp_lt;

   logic              req_xfer, rsp_xfer;
   logic [CNT_W-1:0]  cnt_new;
   logic [IDX_W-1:0]  last_idx;

   nlp_ram #(
      .DEPTH (MAX_LEN),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_EMIT_OUT);
   assign req_xfer   = req_tvalid & req_tready;
   assign rsp_xfer   = rsp_tvalid & rsp_tready;

   assign last_idx   = IDX_W'(cnt_ff - CNT_ONE);
   assign cnt_new    = (cnt_ff < CNT_MAX) ? cnt_ff + CNT_ONE : cnt_ff;

   assign rsp_tdata  = rd_data;
   assign rsp_tuser  = flags_ff;
   assign rsp_tlast  = (idx_ff == last_idx);

   // Scan asks "rd < held", the partner search asks "pivot < rd".
   always_comb begin
      if (state_ff == ST_FIND_CMP) begin
         cmp_a = pval_ff;
         cmp_b = rd_data;
      end else begin
         cmp_a = rd_data;
         cmp_b = cur_ff;
      end
      cmp_lt = (cmp_a < cmp_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         flags_ff <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         flags_ff <= flags_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      hi_ff   <= hi_in;
      piv_ff  <= piv_in;
      pval_ff <= pval_in;
      cur_ff  <= cur_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      flags_in = flags_ff;
      first_in = first_ff;
      idx_in   = idx_ff;
      hi_in    = hi_ff;
      piv_in   = piv_ff;
      pval_in  = pval_ff;
      cur_in   = cur_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = pval_ff;
      rd_en    = 1'b0;
      rd_addr  = idx_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (cnt_ff < CNT_MAX) begin
                  wr_en   = 1'b1;
                  wr_addr = IDX_W'(cnt_ff);
                  wr_data = elem_type'(req_tdata);
               end else begin
                  flags_in.overflow = 1'b1;
               end
               cnt_in = cnt_new;
               if (req_tlast) begin
                  flags_in.found = 1'b0;
                  first_in       = 1'b1;
                  if (cnt_new < CNT_TWO) begin
                     idx_in   = IDX_ZERO;
                     state_in = ST_EMIT_RD;
                  end else begin
                     idx_in   = IDX_W'(cnt_new - CNT_ONE);
                     state_in = ST_SCAN_RD;
                  end
               end
            end
         end

         ST_SCAN_RD: begin
            rd_en    = 1'b1;
            state_in = ST_SCAN_CMP;
         end

         ST_SCAN_CMP: begin
            if (first_ff) begin
               cur_in   = rd_data;
               first_in = 1'b0;
               idx_in   = idx_ff - IDX_ONE;
               state_in = ST_SCAN_RD;
            end else if (cmp_lt) begin
               // rising pair found: this is the pivot
               piv_in         = idx_ff;
               pval_in        = rd_data;
               flags_in.found = 1'b1;
               idx_in         = last_idx;
               state_in       = ST_FIND_RD;
            end else if (idx_ff == IDX_ZERO) begin
               state_in = ST_EMIT_RD;
            end else begin
               cur_in   = rd_data;
               idx_in   = idx_ff - IDX_ONE;
               state_in = ST_SCAN_RD;
            end
         end

         ST_FIND_RD: begin
            rd_en    = 1'b1;
            state_in = ST_FIND_CMP;
         end

         ST_FIND_CMP: begin
            if (cmp_lt) begin
               cur_in   = rd_data;
               state_in = ST_SWAP_J;
            end else begin
               idx_in   = idx_ff - IDX_ONE;
               state_in = ST_FIND_RD;
            end
         end

         ST_SWAP_J: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = pval_ff;
            state_in = ST_SWAP_P;
         end

         ST_SWAP_P: begin
            wr_en    = 1'b1;
            wr_addr  = piv_ff;
            wr_data  = cur_ff;
            idx_in   = piv_ff + IDX_ONE;
            hi_in    = last_idx;
            state_in = ST_REV_CHK;
         end

         ST_REV_CHK: begin
            if (idx_ff < hi_ff) begin
               state_in = ST_REV_RD_LO;
            end else begin
               idx_in   = IDX_ZERO;
               state_in = ST_EMIT_RD;
            end
         end

         ST_REV_RD_LO: begin
            rd_en    = 1'b1;
            state_in = ST_REV_RD_HI;
         end

         ST_REV_RD_HI: begin
            cur_in   = rd_data;
            rd_en    = 1'b1;
            rd_addr  = hi_ff;
            state_in = ST_REV_WR_LO;
         end

         ST_REV_WR_LO: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data;
            state_in = ST_REV_WR_HI;
         end

         ST_REV_WR_HI: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            wr_data  = cur_ff;
            idx_in   = idx_ff + IDX_ONE;
            hi_in    = hi_ff - IDX_ONE;
            state_in = ST_REV_CHK;
         end

         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT_OUT;
         end

         ST_EMIT_OUT: begin
            if (rsp_xfer) begin
               if (idx_ff == last_idx) begin
                  cnt_in   = '0;
                  flags_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + IDX_ONE;
                  state_in = ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule : next_lexicographic_permutation_top

`default_nettype wire

FILE: src/nlp_checker.sv
// ----------------------------------------------------------------------------
// nlp_checker
// Port-level checks on the next lexicographic permutation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nlp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // loading and emitting never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request ready while a result is offered");

   // a non-final element keeps the block loading
   a_keep_loading: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tlast) |=> req_tready)
      else $error("block left loading before the final element");

   // the final result of a frame returns the block to loading
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("block not back to loading after frame end");

   // a stalled result holds its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule : nlp_checker

bind next_lexicographic_permutation_top nlp_checker u_nlp_checker (.*);

`default_nettype wire
